// File: hw/rtl/abts_pkg.sv
// Shared types, constants and a helper function for the block transfer address sequencer.
package abts_pkg;

    localparam int ADDR_W = 32;
    localparam int LIST_W = 16;
    localparam int REG_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [REG_W-1:0]  PC_REG    = 4'd15;
    localparam logic [ADDR_W-1:0] WORD_STEP = 32'd4;

    typedef struct packed {
        logic              kind;
        logic [LIST_W-1:0] reg_list;
        logic [ADDR_W-1:0] base_value;
        logic [REG_W-1:0]  base_reg;
        logic              pre_index;
        logic              ascending;
        logic              write_back;
        logic              s_bit;
    } abts_in_t;

    typedef struct packed {
        logic              transfer_valid;
        logic [ADDR_W-1:0] address;
        logic [REG_W-1:0]  reg_index;
        logic              is_load;
        logic              user_bank;
        logic              restore_status;
        logic              wb_enable;
        logic [REG_W-1:0]  wb_reg;
        logic [ADDR_W-1:0] wb_value;
        logic              wb_before;
        logic              last;
    } abts_out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] op_a;
        logic [ADDR_W-1:0] op_b;
        logic              sub;
    } abts_alu_req_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [REG_W-1:0] lowest_set(input logic [LIST_W-1:0] bits);
        logic [REG_W-1:0] idx;
        idx = '0;
        for (int i = LIST_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = REG_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: hw/rtl/abts_addr_unit.sv
// Shared 32-bit add/subtract unit used for writeback, start and step addresses.
module abts_addr_unit (
    input  abts_pkg::abts_alu_req_t     req,
    output logic [abts_pkg::ADDR_W-1:0] result
);

    always_comb begin
        if (req.sub) begin
            result = req.op_a - req.op_b;
        end else begin
            result = req.op_a + req.op_b;
        end
    end

endmodule

// File: hw/rtl/abts_seq.sv
// Sequencer that walks the register list and drives the shared address unit.
module abts_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  abts_pkg::abts_in_t  s_data,
    input  logic                out_free,
    output logic                emit_valid,
    output abts_pkg::abts_out_t emit_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_FIRST = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    abts_pkg::abts_in_t            item_reg, item_next;
    logic [abts_pkg::LIST_W-1:0]   pend_reg, pend_next;
    logic [abts_pkg::ADDR_W-1:0]   acc_reg, acc_next;
    logic [abts_pkg::ADDR_W-1:0]   wbval_reg, wbval_next;

    abts_pkg::abts_alu_req_t       alu_req;
    logic [abts_pkg::ADDR_W-1:0]   alu_result;
    logic [abts_pkg::CNT_W-1:0]    count;
    logic [abts_pkg::LIST_W-1:0]   low_bit;
    logic [abts_pkg::LIST_W-1:0]   pend_rest;
    logic [abts_pkg::REG_W-1:0]    cur_idx;
    logic                          step_first;
    logic                          empty_list;
    logic                          pc_listed;

    abts_addr_unit u_addr (
        .req    (alu_req),
        .result (alu_result)
    );

    assign count      = abts_pkg::CNT_W'($countones(item_reg.reg_list));
    assign step_first = ~(item_reg.ascending ^ item_reg.pre_index);
    assign empty_list = (item_reg.reg_list == '0);
    assign pc_listed  = item_reg.reg_list[abts_pkg::PC_REG];
    assign low_bit    = pend_reg & (~pend_reg + abts_pkg::LIST_W'(1));
    assign pend_rest  = pend_reg & ~low_bit;
    assign cur_idx    = abts_pkg::lowest_set(pend_reg);

    assign s_ready    = (state_reg == ST_IDLE);
    assign emit_valid = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        alu_req.op_a = acc_reg;
        alu_req.op_b = abts_pkg::WORD_STEP;
        alu_req.sub  = 1'b0;
        if (state_reg == ST_SETUP) begin
            alu_req.op_a = item_reg.base_value;
            alu_req.op_b = {{(abts_pkg::ADDR_W-abts_pkg::CNT_W-2){1'b0}}, count, 2'b00};
            alu_req.sub  = ~item_reg.ascending;
        end
    end

    always_comb begin
        emit_data.transfer_valid = ~empty_list;
        emit_data.address        = empty_list ? '0 : acc_reg;
        emit_data.reg_index      = empty_list ? '0 : cur_idx;
        emit_data.is_load        = item_reg.kind;
        emit_data.user_bank      = ~empty_list & item_reg.s_bit
                                   & ~(item_reg.kind & pc_listed);
        emit_data.restore_status = ~empty_list & item_reg.s_bit & item_reg.kind
                                   & (cur_idx == abts_pkg::PC_REG);
        emit_data.wb_enable      = item_reg.write_back;
        emit_data.wb_reg         = item_reg.base_reg;
        emit_data.wb_value       = wbval_reg;
        emit_data.wb_before      = ~item_reg.ascending;
        emit_data.last           = empty_list || (pend_rest == '0);
    end

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        wbval_next = wbval_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    pend_next  = s_data.reg_list;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                // Descending modes start at the writeback value itself.
                wbval_next = alu_result;
                acc_next   = item_reg.ascending ? item_reg.base_value : alu_result;
                state_next = empty_list ? ST_EMIT : ST_FIRST;
            end
            ST_FIRST: begin
                if (step_first) begin
                    acc_next = alu_result;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    pend_next = pend_rest;
                    acc_next  = alu_result;
                    if (emit_data.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        item_reg  <= item_next;
        pend_reg  <= pend_next;
        acc_reg   <= acc_next;
        wbval_reg <= wbval_next;
    end

endmodule

// File: hw/rtl/arm_block_transfer_address_sequencer_top.sv
// Top level of the block transfer address sequencer with its output register.
//
// One LDM or STM request is taken while the block is idle. The block then
// forms the writeback value and start address in its setup state and the
// first transfer address in its first state, both on a single shared 32-bit
// adder, and after that produces one result per cycle, while the output
// register can take it, for each listed register in ascending order, using
// the same adder to step the address by four. An empty list skips the first
// state and gives a single result with no transfer. Results pass through an
// output register, so a stalled result is held there and also holds the
// sequencer in its emit state.
module arm_block_transfer_address_sequencer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  abts_pkg::abts_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output abts_pkg::abts_out_t m_data
);

    logic                m_valid_reg, m_valid_next;
    abts_pkg::abts_out_t m_data_reg, m_data_next;
    logic                out_free;
    logic                emit_valid;
    abts_pkg::abts_out_t emit_data;

    abts_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit_data  (emit_data)
    );

    assign out_free = ~m_valid_reg | m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // A request is worked on alone: the block cannot take another straight away.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer ready again in the cycle after a request");

    // A result without a transfer only arises for an empty list and is its only result.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.transfer_valid) |-> (m_data.last && m_data.address == '0))
        else $error("empty-list result malformed");

    // Status restore belongs to an r15 load and excludes user bank access.
    a_restore_on_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.restore_status) |->
        (m_data.reg_index == abts_pkg::PC_REG && m_data.is_load && !m_data.user_bank
         && m_data.last))
        else $error("restore_status outside an r15 load");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the LDM/STM block transfer address sequencer.
module testbench;
    import abts_pkg::*;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;
    localparam int   CLK_HALF   = 6;
    localparam int   RUN_LIMIT  = 700000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    abts_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    abts_out_t m_data;

    abts_out_t expected_transfers[$];
    int        mismatch_count = 0;
    bit        idling_on = 1'b1;

    arm_block_transfer_address_sequencer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Works out every transfer that one request gives, in ascending register order.
    function automatic void predict_transfers(input abts_in_t req);
        abts_out_t         res;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] cursor;
        int unsigned       count;
        int unsigned       emitted;
        logic              step_first;
        logic              pc_listed;
        logic              restore_on_pc;
        count     = $countones(req.reg_list);
        span      = ADDR_W'(count) << 2;
        res       = '0;
        res.is_load   = req.kind;
        res.wb_enable = req.write_back;
        res.wb_reg    = req.base_reg;
        res.wb_value  = req.ascending ? req.base_value + span : req.base_value - span;
        res.wb_before = !req.ascending;
        if (count == 0) begin
            res.last = 1'b1;
            expected_transfers.push_back(res);
            return;
        end
        // Descending modes start at the bottom of the block with the P sense inverted.
        cursor        = req.ascending ? req.base_value : req.base_value - span;
        step_first    = req.ascending ? req.pre_index : !req.pre_index;
        pc_listed     = req.reg_list[PC_REG];
        restore_on_pc = req.s_bit && (req.kind == KIND_LOAD) && pc_listed;
        res.transfer_valid = 1'b1;
        res.user_bank      = req.s_bit && !((req.kind == KIND_LOAD) && pc_listed);
        emitted = 0;
        for (int r = 0; r < LIST_W; r++) begin
            if (req.reg_list[r]) begin
                res.address        = step_first ? cursor + WORD_STEP : cursor;
                cursor             = cursor + WORD_STEP;
                res.reg_index      = REG_W'(r);
                res.restore_status = restore_on_pc && (REG_W'(r) == PC_REG);
                emitted++;
                res.last           = (emitted == count);
                expected_transfers.push_back(res);
            end
        end
    endfunction

    function automatic abts_in_t make_request(input logic kind, input logic [LIST_W-1:0] list,
                                              input logic [ADDR_W-1:0] base,
                                              input logic [REG_W-1:0] breg, input logic pre,
                                              input logic asc, input logic wb, input logic s);
        abts_in_t req;
        req.kind       = kind;
        req.reg_list   = list;
        req.base_value = base;
        req.base_reg   = breg;
        req.pre_index  = pre;
        req.ascending  = asc;
        req.write_back = wb;
        req.s_bit      = s;
        return req;
    endfunction

    function automatic abts_in_t random_request();
        abts_in_t req;
        req.kind       = 1'($urandom_range(0, 1));
        req.base_reg   = REG_W'($urandom_range(0, 15));
        req.pre_index  = 1'($urandom_range(0, 1));
        req.ascending  = 1'($urandom_range(0, 1));
        req.write_back = 1'($urandom_range(0, 1));
        req.s_bit      = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       req.reg_list = '0;
            1:       req.reg_list = '1;
            2, 3:    req.reg_list = LIST_W'(1) << $urandom_range(0, 15);
            4:       req.reg_list = LIST_W'($urandom) | (LIST_W'(1) << PC_REG);
            default: req.reg_list = LIST_W'($urandom);
        endcase
        // Bases near either end of the address space exercise the wrap.
        case ($urandom_range(0, 5))
            0:       req.base_value = ADDR_W'($urandom_range(0, 64));
            1:       req.base_value = '1 - ADDR_W'($urandom_range(0, 64));
            2:       req.base_value = $urandom & ~ADDR_W'(3);
            default: req.base_value = $urandom;
        endcase
        return req;
    endfunction

    // Entered and left at a falling edge; valid stays high for a following request.
    task automatic send_request(input abts_in_t req);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_data  = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_transfers(req);
        @(negedge aclk);
    endtask

    task automatic wait_until_drained();
        s_valid = 1'b0;
        while (expected_transfers.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        abts_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_transfers.size() == 0) begin
                $error("result with no request outstanding: 0x%0h", m_data);
                mismatch_count++;
            end else begin
                want = expected_transfers.pop_front();
                check_field("transfer_valid", ADDR_W'(want.transfer_valid),
                            ADDR_W'(m_data.transfer_valid));
                check_field("address", want.address, m_data.address);
                check_field("reg_index", ADDR_W'(want.reg_index), ADDR_W'(m_data.reg_index));
                check_field("is_load", ADDR_W'(want.is_load), ADDR_W'(m_data.is_load));
                check_field("user_bank", ADDR_W'(want.user_bank), ADDR_W'(m_data.user_bank));
                check_field("restore_status", ADDR_W'(want.restore_status),
                            ADDR_W'(m_data.restore_status));
                check_field("wb_enable", ADDR_W'(want.wb_enable), ADDR_W'(m_data.wb_enable));
                check_field("wb_reg", ADDR_W'(want.wb_reg), ADDR_W'(m_data.wb_reg));
                check_field("wb_value", want.wb_value, m_data.wb_value);
                check_field("wb_before", ADDR_W'(want.wb_before), ADDR_W'(m_data.wb_before));
                check_field("last", ADDR_W'(want.last), ADDR_W'(m_data.last));
            end
        end
    end

    // The consumer stalls in random bursts until idling is switched off.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic test_directed_cases();
        // Empty lists in both directions.
        send_request(make_request(KIND_LOAD, 16'h0000, 32'h0000_1000, 4'd1, 1'b0, 1'b1, 1'b1, 1'b0));
        send_request(make_request(KIND_STORE, 16'h0000, 32'h0000_1000, 4'd2, 1'b0, 1'b0, 1'b1, 1'b0));
        // Full list in all four addressing modes.
        send_request(make_request(KIND_LOAD, 16'hFFFF, 32'h0000_2000, 4'd13, 1'b0, 1'b1, 1'b1, 1'b0));
        send_request(make_request(KIND_LOAD, 16'hFFFF, 32'h0000_2000, 4'd13, 1'b1, 1'b1, 1'b0, 1'b0));
        send_request(make_request(KIND_STORE, 16'hFFFF, 32'h0000_2000, 4'd13, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(KIND_STORE, 16'hFFFF, 32'h0000_2000, 4'd13, 1'b1, 1'b0, 1'b1, 1'b0));
        // Addresses wrapping below zero and past the top.
        send_request(make_request(KIND_LOAD, 16'h0001, 32'h0000_0000, 4'd3, 1'b1, 1'b0, 1'b1, 1'b0));
        send_request(make_request(KIND_STORE, 16'h8000, 32'hFFFF_FFFC, 4'd5, 1'b1, 1'b1, 1'b1, 1'b0));
        // User bank and status restore.
        send_request(make_request(KIND_STORE, 16'h5555, 32'h0000_3000, 4'd6, 1'b0, 1'b1, 1'b0, 1'b1));
        send_request(make_request(KIND_LOAD, 16'h7FFF, 32'h0000_3000, 4'd7, 1'b1, 1'b1, 1'b0, 1'b1));
        send_request(make_request(KIND_LOAD, 16'h8001, 32'h0000_3000, 4'd8, 1'b0, 1'b1, 1'b0, 1'b1));
        send_request(make_request(KIND_LOAD, 16'h8000, 32'h0000_3000, 4'd9, 1'b1, 1'b0, 1'b0, 1'b1));
        send_request(make_request(KIND_STORE, 16'h8000, 32'h0000_3000, 4'd10, 1'b0, 1'b0, 1'b0, 1'b1));
        // Base register inside the list, and writeback together with S.
        send_request(make_request(KIND_LOAD, 16'h0010, 32'h0000_4000, 4'd4, 1'b0, 1'b1, 1'b1, 1'b0));
        send_request(make_request(KIND_STORE, 16'h00FF, 32'h0000_4000, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_request(make_request(KIND_LOAD, 16'h00F0, 32'h0000_5000, 4'd11, 1'b0, 1'b1, 1'b1, 1'b1));
        // Extreme base values and register indexes.
        send_request(make_request(KIND_LOAD, 16'hAAAA, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b1, 1'b1, 1'b0));
        send_request(make_request(KIND_STORE, 16'hFFFF, 32'h8000_0000, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_request(make_request(KIND_LOAD, 16'h0000, 32'h0000_0000, 4'd15, 1'b1, 1'b0, 1'b1, 1'b1));
        send_request(make_request(KIND_STORE, 16'h0000, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_random_traffic(input int unsigned n);
        repeat (n) send_request(random_request());
    endtask

    // Each request waits until the block has returned every result of the one before.
    task automatic test_isolated_requests(input int unsigned n);
        repeat (n) begin
            wait_until_drained();
            send_request(random_request());
        end
    endtask

    task automatic test_full_rate(input int unsigned n);
        idling_on = 1'b0;
        repeat (n) send_request(random_request());
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed_cases();
        test_random_traffic(250);
        test_isolated_requests(12);
        test_full_rate(40);
        wait_until_drained();
        repeat (25) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * RUN_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/abts_pkg.sv
hw/rtl/abts_addr_unit.sv
hw/rtl/abts_seq.sv
hw/rtl/arm_block_transfer_address_sequencer_top.sv
tb/testbench.sv
